### design/bblc_pkg.sv
// Shared types, constants and helpers of the Bayer black-level correction block.
// No dependencies; every other design file imports this package.

package bblc_pkg;

   localparam int SAMPLE_BITS_DEFAULT        = 16;
   localparam int GAIN_FRACTION_BITS_DEFAULT = 10;

   localparam int SAMPLE_FIELD_BITS = 16;
   localparam int LEVEL_BITS        = 15;
   localparam int PATTERN_BITS      = 2;
   localparam int PLANE_BITS        = 2;
   localparam int COLOR_BITS        = 2;
   localparam int NUM_COLORS        = 4;
   localparam int CSR_INDEX_BITS    = 3;
   localparam int CSR_DATA_BITS     = 15;

   typedef logic [CSR_INDEX_BITS-1:0] csr_index_type;

   localparam csr_index_type REG_RED_LEVEL        = 3'd0;
   localparam csr_index_type REG_GREEN_RED_LEVEL  = 3'd1;
   localparam csr_index_type REG_GREEN_BLUE_LEVEL = 3'd2;
   localparam csr_index_type REG_BLUE_LEVEL       = 3'd3;
   localparam csr_index_type REG_BAYER_PATTERN    = 3'd4;

   typedef struct packed {
      logic [PLANE_BITS-1:0]        plane;
      logic [SAMPLE_FIELD_BITS-1:0] sample;
   } req_type;

   typedef struct packed {
      logic [SAMPLE_FIELD_BITS-1:0] corrected;
      logic [COLOR_BITS-1:0]        color;
   } rsp_type;

   typedef struct packed {
      logic [NUM_COLORS-1:0][LEVEL_BITS-1:0] level;
      logic [PATTERN_BITS-1:0]               pattern;
   } cal_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

   // RGGB/GRBG/GBRG/BGGR order the 2x2 cell so that the color code is the
   // plane code flipped by the pattern code.
   function automatic logic [COLOR_BITS-1:0] color_of(
      input logic [PATTERN_BITS-1:0] pattern,
      input logic [PLANE_BITS-1:0]   plane
   );
      return COLOR_BITS'(plane ^ pattern);
   endfunction

endpackage

### design/bblc_gain_div.sv
// Restoring divider for the per-color gain: floor((SMAX << FRAC) / divisor).
// One quotient bit per cycle. Depends on bblc_pkg.

module bblc_gain_div
   import bblc_pkg::*;
#(
   parameter int SAMPLE_BITS        = SAMPLE_BITS_DEFAULT,
   parameter int GAIN_FRACTION_BITS = GAIN_FRACTION_BITS_DEFAULT
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      start,
   input  logic [SAMPLE_BITS-1:0]                    divisor,
   output div_status_type                            status,
   output logic [SAMPLE_BITS+GAIN_FRACTION_BITS-1:0] quotient
);

   localparam int NUM_BITS = SAMPLE_BITS + GAIN_FRACTION_BITS;
   localparam int CNT_BITS = $clog2(NUM_BITS);
   localparam logic [NUM_BITS-1:0] NUMERATOR =
      {{SAMPLE_BITS{1'b1}}, {GAIN_FRACTION_BITS{1'b0}}};

   logic                   busy_ff, done_ff;
   logic [CNT_BITS-1:0]    count_ff;
   logic [SAMPLE_BITS-1:0] rem_ff, rem_in;
   logic [SAMPLE_BITS-1:0] divisor_ff;
   logic [NUM_BITS-1:0]    quot_ff;
   logic [SAMPLE_BITS:0]   rem_shift;
   logic                   fits;

   assign rem_shift = {rem_ff, NUMERATOR[count_ff]};
   assign fits      = rem_shift >= {1'b0, divisor_ff};
   assign rem_in    = fits ? SAMPLE_BITS'(rem_shift - {1'b0, divisor_ff})
                           : SAMPLE_BITS'(rem_shift);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff  <= 1'b1;
            count_ff <= CNT_BITS'(NUM_BITS - 1);
         end else if (busy_ff) begin
            if (count_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end else begin
               count_ff <= count_ff - 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff     <= '0;
         divisor_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff  <= rem_in;
         quot_ff <= {quot_ff[NUM_BITS-2:0], fits};
      end
   end

   assign status   = '{busy: busy_ff, done: done_ff};
   assign quotient = quot_ff;

   a_done_after_last_step: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff) && ($past(count_ff) == '0))
      else $error("divider finished without a final step");

endmodule

### design/bblc_csr.sv
// Configuration registers and per-color gain store, with the gain divider.
// Depends on bblc_pkg and bblc_gain_div.

module bblc_csr
   import bblc_pkg::*;
#(
   parameter int SAMPLE_BITS        = SAMPLE_BITS_DEFAULT,
   parameter int GAIN_FRACTION_BITS = GAIN_FRACTION_BITS_DEFAULT
) (
   input  logic                                                  clock,
   input  logic                                                  reset,
   input  logic                                                  csr_valid,
   output logic                                                  csr_ready,
   input  csr_index_type                                         csr_index,
   input  logic [CSR_DATA_BITS-1:0]                              csr_data,
   output cal_type                                               cal,
   output logic [NUM_COLORS-1:0][SAMPLE_BITS+GAIN_FRACTION_BITS-1:0] gains,
   output logic                                                  gain_busy
);

   localparam int GAIN_BITS = SAMPLE_BITS + GAIN_FRACTION_BITS;
   localparam logic [SAMPLE_FIELD_BITS-1:0] SMAX = SAMPLE_FIELD_BITS'((1 << SAMPLE_BITS) - 1);
   localparam logic [GAIN_BITS-1:0] UNITY = GAIN_BITS'(1) << GAIN_FRACTION_BITS;

   cal_type                                   cal_ff;
   logic [NUM_COLORS-1:0][GAIN_BITS-1:0]      gain_ff;
   logic [COLOR_BITS-1:0]                     target_ff;
   logic                                      wr;
   logic                                      level_wr;
   logic [LEVEL_BITS-1:0]                     level_in;
   logic                                      level_full;
   logic                                      div_start;
   logic [SAMPLE_BITS-1:0]                    divisor;
   div_status_type                            div_status;
   logic [GAIN_BITS-1:0]                      quotient;

   assign csr_ready  = !(div_status.busy || div_status.done);
   assign wr         = csr_valid && csr_ready;
   assign level_in   = csr_data[LEVEL_BITS-1:0];
   assign level_full = {1'b0, level_in} >= SMAX;
   assign divisor    = SAMPLE_BITS'(SMAX - {1'b0, level_in});
   assign div_start  = wr && level_wr && !level_full;

   always_comb begin
      unique case (csr_index)
         REG_RED_LEVEL, REG_GREEN_RED_LEVEL,
         REG_GREEN_BLUE_LEVEL, REG_BLUE_LEVEL: level_wr = 1'b1;
         default:                              level_wr = 1'b0;
      endcase
   end

   bblc_gain_div #(
      .SAMPLE_BITS        (SAMPLE_BITS),
      .GAIN_FRACTION_BITS (GAIN_FRACTION_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .divisor  (divisor),
      .status   (div_status),
      .quotient (quotient)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_ff    <= '0;
         gain_ff   <= {NUM_COLORS{UNITY}};
         target_ff <= '0;
      end else begin
         if (wr && level_wr) begin
            cal_ff.level[csr_index[COLOR_BITS-1:0]] <= level_in;
            target_ff <= csr_index[COLOR_BITS-1:0];
            // level at or past full scale: unity gain, no division
            if (level_full) begin
               gain_ff[csr_index[COLOR_BITS-1:0]] <= UNITY;
            end
         end else if (wr && csr_index == REG_BAYER_PATTERN) begin
            cal_ff.pattern <= csr_data[PATTERN_BITS-1:0];
         end
         if (div_status.done) begin
            gain_ff[target_ff] <= quotient;
         end
      end
   end

   assign cal       = cal_ff;
   assign gains     = gain_ff;
   assign gain_busy = div_status.busy;

   a_start_runs_divider: assert property (@(posedge clock) disable iff (reset)
      div_start |=> div_status.busy && !csr_ready)
      else $error("level write did not start a gain update");

endmodule

### design/bblc_datapath.sv
// Sample path: input register, level subtract, gain multiply, saturate, result register.
// Depends on bblc_pkg.

module bblc_datapath
   import bblc_pkg::*;
#(
   parameter int SAMPLE_BITS        = SAMPLE_BITS_DEFAULT,
   parameter int GAIN_FRACTION_BITS = GAIN_FRACTION_BITS_DEFAULT
) (
   input  logic                                                  clock,
   input  logic                                                  reset,
   input  logic                                                  req_valid,
   output logic                                                  req_ready,
   input  req_type                                               req_data,
   output logic                                                  rsp_valid,
   input  logic                                                  rsp_ready,
   output rsp_type                                               rsp_data,
   input  cal_type                                               cal,
   input  logic [NUM_COLORS-1:0][SAMPLE_BITS+GAIN_FRACTION_BITS-1:0] gains,
   input  logic                                                  gain_busy
);

   localparam int GAIN_BITS = SAMPLE_BITS + GAIN_FRACTION_BITS;
   localparam int PROD_BITS = SAMPLE_BITS + GAIN_BITS;
   localparam logic [SAMPLE_FIELD_BITS-1:0] SMAX = SAMPLE_FIELD_BITS'((1 << SAMPLE_BITS) - 1);

   logic                         s1_valid_ff;
   req_type                      s1_data_ff;
   logic                         rsp_valid_ff;
   rsp_type                      rsp_data_ff, rsp_data_in;
   logic                         out_free, s1_free, s1_adv;
   logic [COLOR_BITS-1:0]        color;
   logic [SAMPLE_FIELD_BITS-1:0] level, clamped, diff_wide;
   logic [SAMPLE_BITS-1:0]       diff, scaled;
   logic [PROD_BITS-1:0]         product;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign s1_free   = !s1_valid_ff || out_free;
   assign s1_adv    = s1_valid_ff && out_free;
   assign req_ready = s1_free && !gain_busy;

   always_comb begin
      color     = color_of(cal.pattern, s1_data_ff.plane);
      level     = SAMPLE_FIELD_BITS'(cal.level[color]);
      clamped   = (s1_data_ff.sample > SMAX) ? SMAX : s1_data_ff.sample;
      diff_wide = (clamped > level) ? clamped - level : '0;
      diff      = diff_wide[SAMPLE_BITS-1:0];
      product   = PROD_BITS'(diff) * PROD_BITS'(gains[color]);
      if (|product[PROD_BITS-1:GAIN_FRACTION_BITS+SAMPLE_BITS]) begin
         scaled = '1;
      end else begin
         scaled = product[GAIN_FRACTION_BITS +: SAMPLE_BITS];
      end
      rsp_data_in.corrected = SAMPLE_FIELD_BITS'(scaled);
      rsp_data_in.color     = color;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (s1_free) begin
            s1_valid_ff <= req_valid && req_ready;
         end
         if (out_free) begin
            rsp_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_data_ff <= req_data;
      end
      if (s1_adv) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_result_from_stage: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s1_valid_ff))
      else $error("result appeared without a word in the input stage");

   a_full_pipe_blocks: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && rsp_valid_ff && !rsp_ready |-> !req_ready)
      else $error("word accepted while both stages are held");

endmodule

### design/bayer_black_level_correct_rescale_top.sv
// Top level of the Bayer black-level correction and rescale block.
// Depends on bblc_pkg, bblc_csr and bblc_datapath.
//
//  channel  direction  handshake               payload
//  req      in         req_valid / req_ready   req_data (plane, sample)
//  rsp      out        rsp_valid / rsp_ready   rsp_data (corrected, color)
//  csr      in         csr_valid / csr_ready   csr_index, csr_data
//
// One word per cycle while rsp is not stalled and no gain is being recomputed; a taken word
// passes through the input register and the result register. A level write below full scale
// reruns that color's gain division, one quotient bit per cycle, and one at or past full
// scale sets unity gain; csr is held off until the gain lands, req while the divider is busy.
// Reset is synchronous: levels and pattern clear, gains return to unity.
// A stall on rsp holds the result register; the input stage still takes a word while empty.

module bayer_black_level_correct_rescale_top
   import bblc_pkg::*;
#(
   parameter int SAMPLE_BITS        = SAMPLE_BITS_DEFAULT,
   parameter int GAIN_FRACTION_BITS = GAIN_FRACTION_BITS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  req_type                  req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output rsp_type                  rsp_data,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  csr_index_type            csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_data
);

   localparam int GAIN_BITS = SAMPLE_BITS + GAIN_FRACTION_BITS;

   cal_type                              cal;
   logic [NUM_COLORS-1:0][GAIN_BITS-1:0] gains;
   logic                                 gain_busy;

   // registers, gain store and the divider that refreshes it
   bblc_csr #(
      .SAMPLE_BITS        (SAMPLE_BITS),
      .GAIN_FRACTION_BITS (GAIN_FRACTION_BITS)
   ) u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cal       (cal),
      .gains     (gains),
      .gain_busy (gain_busy)
   );

   // sample path; hold off new words while a gain is being recomputed
   bblc_datapath #(
      .SAMPLE_BITS        (SAMPLE_BITS),
      .GAIN_FRACTION_BITS (GAIN_FRACTION_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .cal       (cal),
      .gains     (gains),
      .gain_busy (gain_busy)
   );

endmodule

### tb/testbench.sv
// Self-checking testbench of bayer_black_level_correct_rescale_top.
// Depends on bblc_pkg and the design files; it predicts every result word itself
// and checks each one as it leaves the rsp channel.

module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import bblc_pkg::*;

   // Full scale of a sample and the fixed point of the gains.
   localparam int SMAX        = (1 << SAMPLE_BITS_DEFAULT) - 1;
   localparam int FRAC_BITS   = GAIN_FRACTION_BITS_DEFAULT;
   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = 16;
   localparam int PHASES       = 14;
   localparam int PHASE_WORDS  = 125;

   typedef enum logic [COLOR_BITS-1:0] {
      COLOR_R, COLOR_GR, COLOR_GB, COLOR_B
   } color_type;

   typedef enum logic [PATTERN_BITS-1:0] {
      PATTERN_RGGB, PATTERN_GRBG, PATTERN_GBRG, PATTERN_BGGR
   } pattern_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_ready;
   req_type       req_data = '0;
   logic          rsp_valid;
   logic          rsp_ready = 1'b0;
   rsp_type       rsp_data;
   logic          csr_valid = 1'b0;
   logic          csr_ready;
   csr_index_type csr_index = '0;
   logic [CSR_DATA_BITS-1:0] csr_data = '0;

   // Calibration as the block should hold it.
   int unsigned   black_level[NUM_COLORS];
   int unsigned   color_gain[NUM_COLORS];
   pattern_type   cfa_pattern;

   rsp_type       expected_pixels[$];

   bit            quiet = 1'b0;       // no gaps on either side while set
   int            rsp_hold_cycles = 0; // one long rsp stall, picked up by the receiver
   int            error_count = 0;
   int            sent_count = 0;
   int            checked_count = 0;
   int            write_count = 0;
   int            cycle_count = 0;

   bayer_black_level_correct_rescale_top u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Give up if the run hangs.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d words pending", cycle_count,
                  expected_pixels.size());
         $display("TB_ERROR");
         $finish;
      end
   end

   // Map a position in the 2x2 cell to its color under a pattern.
   function automatic color_type plane_color(input pattern_type pat, input logic [1:0] plane);
      color_type order[4];
      case (pat)
         PATTERN_RGGB: order = '{COLOR_R, COLOR_GR, COLOR_GB, COLOR_B};
         PATTERN_GRBG: order = '{COLOR_GR, COLOR_R, COLOR_B, COLOR_GB};
         PATTERN_GBRG: order = '{COLOR_GB, COLOR_B, COLOR_R, COLOR_GR};
         default:      order = '{COLOR_B, COLOR_GB, COLOR_GR, COLOR_R};
      endcase
      return order[plane];
   endfunction

   // Rescale gain that maps the range above the level back to full scale.
   function automatic int unsigned level_gain(input int unsigned level);
      longint unsigned full;
      full = longint'(SMAX) << FRAC_BITS;
      if (level >= SMAX) return 1 << FRAC_BITS;
      return int'(full / (SMAX - level));
   endfunction

   // Corrected sample for one input word under the current calibration.
   function automatic rsp_type corrected_pixel(input req_type word);
      color_type       col;
      longint unsigned value;
      longint unsigned diff;
      longint unsigned scaled;
      rsp_type         result;
      col   = plane_color(cfa_pattern, word.plane);
      value = 64'(word.sample);
      if (value > SMAX) value = SMAX;
      diff   = (value > black_level[col]) ? value - black_level[col] : 0;
      scaled = (diff * color_gain[col]) >> FRAC_BITS;
      if (scaled > SMAX) scaled = SMAX;
      result.corrected = scaled[SAMPLE_FIELD_BITS-1:0];
      result.color     = col;
      return result;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
      error_count++;
   endtask

   // Offer one word on req after a random gap; hold it until it is taken, then
   // queue its prediction. Valid stays high for a following word with no gap.
   task automatic send_pixel(input logic [1:0] plane, input logic [15:0] sample);
      req_type word;
      int      gap;
      word.plane  = plane;
      word.sample = sample;
      gap = quiet ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= word;
      do @(posedge clock); while (!req_ready);
      expected_pixels.push_back(corrected_pixel(word));
      sent_count++;
   endtask

   // Write one register once the block has drained, and track it in the
   // calibration copy. Indexes past the pattern register must be ignored.
   task automatic write_register(input csr_index_type idx, input logic [CSR_DATA_BITS-1:0] data);
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_pixels.size() != 0);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == REG_BAYER_PATTERN) begin
         cfa_pattern = pattern_type'(data[PATTERN_BITS-1:0]);
      end else if (idx < REG_BAYER_PATTERN) begin
         black_level[idx] = 32'(data);
         color_gain[idx]  = level_gain(32'(data));
      end
      write_count++;
   endtask

   // Random sample, biased toward the level of the color it lands on.
   task automatic send_random_pixel();
      logic [1:0]  plane;
      int          value;
      color_type   col;
      plane = 2'($urandom_range(0, 3));
      col   = plane_color(cfa_pattern, plane);
      case ($urandom_range(0, 7))
         0: value = $urandom_range(0, 1) ? SMAX : 0;
         1, 2: begin
            value = int'(black_level[col]) + int'($urandom_range(0, 32)) - 16;
            if (value < 0) value = 0;
         end
         default: value = $urandom_range(0, SMAX);
      endcase
      send_pixel(plane, value[15:0]);
   endtask

   // Check every word that leaves rsp against the oldest prediction.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_pixels.size() == 0) begin
            report_mismatch("unexpected word, corrected", rsp_data.corrected, -1);
         end else begin
            want = expected_pixels.pop_front();
            if (rsp_data.corrected !== want.corrected)
               report_mismatch("corrected", rsp_data.corrected, want.corrected);
            if (rsp_data.color !== want.color)
               report_mismatch("color", rsp_data.color, want.color);
            checked_count++;
         end
      end
   end

   // Receiver: random stall before each word, plus one long hold when asked.
   initial begin
      int stall;
      while (reset) @(posedge clock);
      forever begin
         if (rsp_hold_cycles > 0) begin
            rsp_ready <= 1'b0;
            repeat (rsp_hold_cycles) @(posedge clock);
            rsp_hold_cycles = 0;
         end
         stall = quiet ? 0 : $urandom_range(0, 3);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // Unity gains and zero levels out of reset: each word passes unchanged.
   task automatic test_reset_passthrough();
      send_pixel(2'd0, 16'h0000);
      send_pixel(2'd1, 16'hffff);
      send_pixel(2'd2, 16'h8000);
      send_pixel(2'd3, 16'h7fff);
   endtask

   // Extreme levels under every pattern: samples below, at and above the
   // level, and full scale. Pattern writes carry junk in the upper bits.
   task automatic test_level_corners();
      logic [15:0] corners[4];
      corners = '{16'h0000, 16'hffff, 16'h7fff, 16'h8000};
      write_register(REG_RED_LEVEL, 15'h7fff);
      write_register(REG_GREEN_RED_LEVEL, 15'h0000);
      write_register(REG_GREEN_BLUE_LEVEL, 15'h0001);
      write_register(REG_BLUE_LEVEL, 15'h7ffe);
      for (int p = 0; p < 4; p++) begin
         write_register(REG_BAYER_PATTERN, CSR_DATA_BITS'(15'h7ffc | p));
         for (int k = 0; k < 4; k++) send_pixel(k[1:0], corners[(p + k) % 4]);
      end
      // Unused indexes must leave the calibration alone.
      for (int idx = REG_BAYER_PATTERN + 1; idx < (1 << CSR_INDEX_BITS); idx++)
         write_register(csr_index_type'(idx), 15'h7fff);
      send_pixel(2'd0, 16'hc000);
   endtask

   // Phases of random traffic, each under a fresh random calibration.
   task automatic test_random_phases();
      int unsigned level;
      for (int phase = 0; phase < PHASES; phase++) begin
         for (int idx = REG_RED_LEVEL; idx <= REG_BLUE_LEVEL; idx++) begin
            if (phase == 0 || $urandom_range(0, 1)) begin
               case ($urandom_range(0, 5))
                  0: level = 0;
                  1: level = (1 << LEVEL_BITS) - 1;
                  2: level = $urandom_range(0, 255);
                  default: level = $urandom_range(0, (1 << LEVEL_BITS) - 1);
               endcase
               write_register(csr_index_type'(idx), level[CSR_DATA_BITS-1:0]);
            end
         end
         write_register(REG_BAYER_PATTERN,
                        CSR_DATA_BITS'($urandom_range(0, (1 << CSR_DATA_BITS) - 1)));
         if ($urandom_range(0, 3) == 0)
            write_register(csr_index_type'($urandom_range(REG_BAYER_PATTERN + 1,
                                                          (1 << CSR_INDEX_BITS) - 1)),
                           CSR_DATA_BITS'($urandom_range(0, (1 << CSR_DATA_BITS) - 1)));
         // Every fifth phase runs back to back with no gaps on either side.
         quiet = (phase % 5 == 4);
         repeat (PHASE_WORDS) send_random_pixel();
         quiet = 1'b0;
      end
   endtask

   // Hold rsp for a long stretch while req keeps offering words, so the block
   // fills up and drops req_ready.
   task automatic test_output_backpressure();
      rsp_hold_cycles = 64;
      quiet = 1'b1;
      repeat (48) send_random_pixel();
      quiet = 1'b0;
   endtask

   initial begin
      for (int c = 0; c < NUM_COLORS; c++) begin
         black_level[c] = 0;
         color_gain[c]  = 1 << FRAC_BITS;
      end
      cfa_pattern = PATTERN_RGGB;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_reset_passthrough();
      test_level_corners();
      test_random_phases();
      test_output_backpressure();

      // Drop valid, wait for the last words, then watch for strays.
      req_valid <= 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("sent %0d samples and checked %0d words over %0d register writes",
               sent_count, checked_count, write_count);
      $display("all four patterns, level extremes, random gaps and a long output stall");
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("%0d mismatches", error_count);
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

### filelist.f
design/bblc_pkg.sv
design/bblc_gain_div.sv
design/bblc_csr.sv
design/bblc_datapath.sv
design/bayer_black_level_correct_rescale_top.sv
tb/testbench.sv
